FILE: rtl/owsm_pkg.sv
// Shared package of the omni wheel speed mixer: field widths, command and
// register codes, the microcode control word and the sequencer program.
// No dependencies; the top level refers to it by scoped names.
`default_nettype none

package owsm_pkg;

    // Field widths of the stream and register ports.
    localparam int SPEED_W = 16;
    localparam int CMD_W   = 2;
    localparam int ARM_W   = 16;
    localparam int MAXS_W  = 15;
    localparam int AGE_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;

    // Internal datapath widths.
    localparam int ACC_W   = 35;  // exact wheel sum with 16 extra fraction bits
    localparam int RND_SH  = 16;  // fraction bits dropped by rounding
    localparam int WHL_W   = ACC_W - RND_SH;  // rounded wheel, signed
    localparam int MAG_W   = WHL_W - 1;       // wheel magnitude, unsigned
    localparam int MUL_A_W = WHL_W;
    localparam int MUL_B_W = ARM_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int QUO_W   = MAXS_W;          // quotient never exceeds the limit
    localparam int CNT_W   = 4;
    localparam int PC_W    = 4;
    localparam int LANES   = 3;

    // sqrt(3)/2 as unsigned Q0.16.
    localparam logic [ARM_W-1:0] SQRT3_HALF_Q16 = 16'd56756;

    // Rounding bias: ties away from zero as one add and an arithmetic shift.
    localparam logic signed [ACC_W-1:0] RND_BIAS_POS = 35'sd32768;
    localparam logic signed [ACC_W-1:0] RND_BIAS_NEG = 35'sd32767;

    // Saturation value of the command age.
    localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

    // Wheel lane indexes.
    localparam logic [1:0] WHL_LEFT  = 2'd0;
    localparam logic [1:0] WHL_FRONT = 2'd1;
    localparam logic [1:0] WHL_RIGHT = 2'd2;

    // Command codes carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_VEL   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_ARM     = 2'd1,
        REG_MAXS    = 2'd2,
        REG_TIMEOUT = 2'd3
    } t_reg;

    // Multiplier operand selection.
    typedef enum logic [1:0] {
        MS_NONE = 2'd0,
        MS_FX   = 2'd1,
        MS_ROT  = 2'd2,
        MS_MAG  = 2'd3
    } t_mul_sel;

    // Destination of the registered product.
    typedef enum logic [1:0] {
        CAP_NONE = 2'd0,
        CAP_FX   = 2'd1,
        CAP_ROT  = 2'd2,
        CAP_DIV  = 2'd3
    } t_cap_sel;

    // Jump conditions.
    typedef enum logic [2:0] {
        CJ_NONE        = 3'd0,
        CJ_FORCED      = 3'd1,
        CJ_NOT_OVER    = 3'd2,
        CJ_CNT_NZ      = 3'd3,
        CJ_OUT_BLOCKED = 3'd4
    } t_cond;

    // One control word of the program.
    typedef struct packed {
        t_mul_sel          mul_sel;
        logic [1:0]        mul_idx;
        t_cap_sel          cap;
        logic [1:0]        cap_idx;
        logic              sum_en;
        logic [1:0]        sum_idx;
        logic              rnd_en;
        logic [1:0]        rnd_idx;
        logic              mag_en;
        logic              peak_en;
        logic              cnt_ld;
        logic              div_step;
        logic              fix;
        logic              emit;
        t_cond             cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    // Program labels.
    localparam logic [PC_W-1:0] STEP_DIV  = 4'd13;
    localparam logic [PC_W-1:0] STEP_EMIT = 4'd15;

    // Iterations of the restoring divider, loaded as count minus one.
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    // Sequencer program, one control word per step.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            4'd0: begin
                w.mul_sel = MS_FX;
                w.cond    = CJ_FORCED;
                w.target  = STEP_EMIT;
            end
            4'd1: begin
                w.mul_sel = MS_ROT;
                w.cap     = CAP_FX;
            end
            4'd2: begin
                w.cap = CAP_ROT;
            end
            4'd3: begin
                w.sum_en  = 1'b1;
                w.sum_idx = WHL_LEFT;
            end
            4'd4: begin
                w.sum_en  = 1'b1;
                w.sum_idx = WHL_FRONT;
                w.rnd_en  = 1'b1;
                w.rnd_idx = WHL_LEFT;
            end
            4'd5: begin
                w.sum_en  = 1'b1;
                w.sum_idx = WHL_RIGHT;
                w.rnd_en  = 1'b1;
                w.rnd_idx = WHL_FRONT;
            end
            4'd6: begin
                w.rnd_en  = 1'b1;
                w.rnd_idx = WHL_RIGHT;
            end
            4'd7: begin
                w.mag_en = 1'b1;
            end
            4'd8: begin
                w.peak_en = 1'b1;
            end
            4'd9: begin
                w.mul_sel = MS_MAG;
                w.mul_idx = WHL_LEFT;
                w.cond    = CJ_NOT_OVER;
                w.target  = STEP_EMIT;
            end
            4'd10: begin
                w.mul_sel = MS_MAG;
                w.mul_idx = WHL_FRONT;
                w.cap     = CAP_DIV;
                w.cap_idx = WHL_LEFT;
            end
            4'd11: begin
                w.mul_sel = MS_MAG;
                w.mul_idx = WHL_RIGHT;
                w.cap     = CAP_DIV;
                w.cap_idx = WHL_FRONT;
            end
            4'd12: begin
                w.cap     = CAP_DIV;
                w.cap_idx = WHL_RIGHT;
                w.cnt_ld  = 1'b1;
            end
            4'd13: begin
                w.div_step = 1'b1;
                w.cond     = CJ_CNT_NZ;
                w.target   = STEP_DIV;
            end
            4'd14: begin
                w.fix = 1'b1;
            end
            4'd15: begin
                w.emit   = 1'b1;
                w.cond   = CJ_OUT_BLOCKED;
                w.target = STEP_EMIT;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/omni_wheel_speed_mixer.sv
// Top level of the omni wheel speed mixer: command decode, register port,
// a microcoded sequencer with one multiplier, and three divider lanes.
// Depends on owsm_pkg for widths, codes and the sequencer program.
//
//  Channel   | Direction | Transfer carries
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | tuser: cmd; tdata: forward, lateral, yaw
//  m_axis    | out       | tdata: left, front, right wheel; tuser: forced
//  APB       | in/out    | enable, arm length, speed limit, timeout
//
// Velocity, stop and reset commands and disabled ticks do not start the program.
// An enabled tick runs it: it goes straight to the output step when the output
// is forced to zero, skips the divider when no wheel exceeds the limit, and
// otherwise normalizes the wheels with the 15 iterations of the restoring divider.
// A new command is accepted once the sequencer is idle, while an earlier
// result may still wait in the output register; a stalled output holds the
// program at its last step. Reset is synchronous and needs no clearing pass.
`default_nettype none

module omni_wheel_speed_mixer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [47:0]           s_axis_tdata,   // vel_forward, vel_lateral, yaw_rate
    input  wire logic [1:0]            s_axis_tuser,   // cmd
    // Output stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,   // wheel_left, wheel_front, wheel_right
    output logic [0:0]                 m_axis_tuser,   // forced_zero
    // Register port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int SW    = owsm_pkg::SPEED_W;
    localparam int ACC_W = owsm_pkg::ACC_W;
    localparam int WHL_W = owsm_pkg::WHL_W;
    localparam int MAG_W = owsm_pkg::MAG_W;
    localparam int QUO_W = owsm_pkg::QUO_W;

    // Configuration registers.
    logic                          r_enable;
    logic [owsm_pkg::ARM_W-1:0]    r_arm;
    logic [owsm_pkg::MAXS_W-1:0]   r_maxs;
    logic [owsm_pkg::AGE_W-1:0]    r_timeout;

    // Command state.
    logic signed [SW-1:0]          r_fwd;
    logic signed [SW-1:0]          r_lat;
    logic signed [SW-1:0]          r_yaw;
    logic                          r_stop;
    logic [owsm_pkg::AGE_W-1:0]    r_age;
    logic [owsm_pkg::AGE_W-1:0]    w_age_next;

    // Sequencer.
    logic                          r_busy;
    logic [owsm_pkg::PC_W-1:0]     r_pc;
    logic [owsm_pkg::PC_W-1:0]     n_pc;
    owsm_pkg::t_uword              w_uw;
    logic                          w_jump;
    logic                          r_forced;
    logic [owsm_pkg::CNT_W-1:0]    r_cnt;

    // Datapath.
    logic signed [owsm_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [owsm_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [owsm_pkg::PROD_W-1:0]  w_prod;
    logic signed [owsm_pkg::PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]       r_fx;
    logic signed [ACC_W-1:0]       r_rot;
    logic signed [ACC_W-1:0]       w_lh;
    logic signed [ACC_W-1:0]       w_lf;
    logic signed [ACC_W-1:0]       w_sum;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       w_bias;
    logic signed [ACC_W-1:0]       w_rnd_sum;
    logic signed [WHL_W-1:0]       r_w   [owsm_pkg::LANES];
    logic [MAG_W-1:0]              r_mag [owsm_pkg::LANES];
    logic [MAG_W-1:0]              w_max01;
    logic [MAG_W-1:0]              w_peak;
    logic [MAG_W-1:0]              r_peak;
    logic                          w_over;

    // Divider lanes: partial remainder and dividend/quotient shift register.
    logic [MAG_W-1:0]              r_rem   [owsm_pkg::LANES];
    logic [QUO_W-1:0]              r_dq    [owsm_pkg::LANES];
    logic [MAG_W:0]                w_trial [owsm_pkg::LANES];
    logic [MAG_W:0]                w_diff  [owsm_pkg::LANES];
    logic                          w_ge    [owsm_pkg::LANES];

    // Output register.
    logic                          r_m_valid;
    logic [47:0]                   r_m_data;
    logic                          r_m_forced;
    logic                          w_out_blocked;

    logic                          w_in_xfer;
    logic                          w_cfg_wr;
    owsm_pkg::t_cmd                w_cmd;
    owsm_pkg::t_reg                w_reg;

    // Handshakes and port decode.
    assign s_axis_tready = !r_busy;
    assign w_in_xfer     = s_axis_tvalid && !r_busy;
    assign w_cmd         = owsm_pkg::t_cmd'(s_axis_tuser);
    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite;
    assign w_reg         = owsm_pkg::t_reg'(paddr[3:2]);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_forced;
    assign w_out_blocked = r_m_valid && !m_axis_tready;

    // Register read-back.
    always_comb begin
        case (w_reg)
            owsm_pkg::REG_ENABLE:  prdata = {31'd0, r_enable};
            owsm_pkg::REG_ARM:     prdata = {16'd0, r_arm};
            owsm_pkg::REG_MAXS:    prdata = {17'd0, r_maxs};
            owsm_pkg::REG_TIMEOUT: prdata = {16'd0, r_timeout};
            default:               prdata = '0;
        endcase
    end

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_arm     <= 16'd7864;
            r_maxs    <= 15'd786;
            r_timeout <= 16'd50;
        end else if (w_cfg_wr) begin
            case (w_reg)
                owsm_pkg::REG_ENABLE:  r_enable  <= pwdata[0];
                owsm_pkg::REG_ARM:     r_arm     <= pwdata[15:0];
                owsm_pkg::REG_MAXS:    r_maxs    <= pwdata[14:0];
                owsm_pkg::REG_TIMEOUT: r_timeout <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Saturating age for the next tick.
    assign w_age_next = (r_age == owsm_pkg::AGE_MAX) ? r_age : r_age + 1'b1;

    // Command decode: stored rates, stop latch and command age.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd  <= '0;
            r_lat  <= '0;
            r_yaw  <= '0;
            r_stop <= 1'b0;
            r_age  <= '0;
        end else if (w_in_xfer) begin
            case (w_cmd)
                owsm_pkg::CMD_VEL: begin
                    r_fwd <= s_axis_tdata[15:0];
                    r_lat <= s_axis_tdata[31:16];
                    r_yaw <= s_axis_tdata[47:32];
                    r_age <= '0;
                end
                owsm_pkg::CMD_TICK: begin
                    if (r_enable) begin
                        r_age <= w_age_next;
                    end
                end
                owsm_pkg::CMD_STOP: begin
                    r_stop <= 1'b1;
                end
                owsm_pkg::CMD_RESET: begin
                    r_fwd  <= '0;
                    r_lat  <= '0;
                    r_yaw  <= '0;
                    r_stop <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control word fetch and next step.
    always_comb begin
        w_uw = owsm_pkg::ucode(r_pc);
        case (w_uw.cond)
            owsm_pkg::CJ_NONE:        w_jump = 1'b0;
            owsm_pkg::CJ_FORCED:      w_jump = r_forced;
            owsm_pkg::CJ_NOT_OVER:    w_jump = !w_over;
            owsm_pkg::CJ_CNT_NZ:      w_jump = (r_cnt != '0);
            owsm_pkg::CJ_OUT_BLOCKED: w_jump = w_out_blocked;
            default:                  w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + 1'b1;
    end

    // Sequencer state: an enabled tick starts the program at step zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (w_in_xfer && w_cmd == owsm_pkg::CMD_TICK && r_enable) begin
            r_busy <= 1'b1;
            r_pc   <= '0;
        end else if (r_busy) begin
            r_pc <= n_pc;
            if (w_uw.emit && !w_out_blocked) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Stop latch or timeout decides the zero output at tick start.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_forced <= r_stop || (w_age_next > r_timeout);
        end
    end

    // Multiplier operand selection.
    always_comb begin
        case (w_uw.mul_sel)
            owsm_pkg::MS_FX: begin
                w_mul_a = owsm_pkg::MUL_A_W'(r_fwd);
                w_mul_b = signed'({1'b0, owsm_pkg::SQRT3_HALF_Q16});
            end
            owsm_pkg::MS_ROT: begin
                w_mul_a = owsm_pkg::MUL_A_W'(r_yaw);
                w_mul_b = signed'({1'b0, r_arm});
            end
            owsm_pkg::MS_MAG: begin
                w_mul_a = signed'({1'b0, r_mag[w_uw.mul_idx]});
                w_mul_b = signed'({2'b00, r_maxs});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // Wheel sums: lateral half and full terms are plain shifts.
    assign w_lh = {{(ACC_W - SW - 15){r_lat[SW-1]}}, r_lat, 15'd0};
    assign w_lf = {{(ACC_W - SW - 16){r_lat[SW-1]}}, r_lat, 16'd0};
    always_comb begin
        case (w_uw.sum_idx)
            owsm_pkg::WHL_LEFT:  w_sum = r_fx + w_lh - r_rot;
            owsm_pkg::WHL_FRONT: w_sum = -w_lf - r_rot;
            owsm_pkg::WHL_RIGHT: w_sum = w_lh - r_fx - r_rot;
            default:             w_sum = '0;
        endcase
    end

    // Round to nearest, ties away from zero, as one add and a shift.
    assign w_bias    = r_acc[ACC_W-1] ? owsm_pkg::RND_BIAS_NEG : owsm_pkg::RND_BIAS_POS;
    assign w_rnd_sum = r_acc + w_bias;

    // Peak magnitude over the three lanes and the limit compare.
    assign w_max01 = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
    assign w_peak  = (r_mag[2] > w_max01) ? r_mag[2] : w_max01;
    assign w_over  = r_peak > MAG_W'(r_maxs);

    // One restoring step per lane.
    always_comb begin
        for (int i = 0; i < owsm_pkg::LANES; i++) begin
            w_trial[i] = {r_rem[i], r_dq[i][QUO_W-1]};
            w_diff[i]  = w_trial[i] - {1'b0, r_peak};
            w_ge[i]    = w_trial[i] >= {1'b0, r_peak};
        end
    end

    // Datapath registers, each driven by its field of the control word.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_prod <= w_prod;
            case (w_uw.cap)
                owsm_pkg::CAP_FX:  r_fx  <= r_prod[ACC_W-1:0];
                owsm_pkg::CAP_ROT: r_rot <= r_prod[ACC_W-1:0];
                owsm_pkg::CAP_DIV: begin
                    r_rem[w_uw.cap_idx] <= r_prod[MAG_W+QUO_W-1:QUO_W];
                    r_dq[w_uw.cap_idx]  <= r_prod[QUO_W-1:0];
                end
                default: begin
                end
            endcase
            if (w_uw.sum_en) begin
                r_acc <= w_sum;
            end
            if (w_uw.rnd_en) begin
                r_w[w_uw.rnd_idx] <= w_rnd_sum[ACC_W-1:owsm_pkg::RND_SH];
            end
            if (w_uw.peak_en) begin
                r_peak <= w_peak;
            end
            if (w_uw.cnt_ld) begin
                r_cnt <= owsm_pkg::DIV_LAST;
            end else if (w_uw.div_step && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            for (int i = 0; i < owsm_pkg::LANES; i++) begin
                if (w_uw.mag_en) begin
                    r_mag[i] <= r_w[i][WHL_W-1] ? MAG_W'(-r_w[i]) : MAG_W'(r_w[i]);
                end
                if (w_uw.div_step) begin
                    r_rem[i] <= w_ge[i] ? w_diff[i][MAG_W-1:0] : w_trial[i][MAG_W-1:0];
                    r_dq[i]  <= {r_dq[i][QUO_W-2:0], w_ge[i]};
                end
                // Restore the wheel's sign on the truncated quotient.
                if (w_uw.fix) begin
                    r_w[i] <= r_w[i][WHL_W-1] ? -signed'(WHL_W'(r_dq[i]))
                                              : signed'(WHL_W'(r_dq[i]));
                end
            end
        end
    end

    // Output register: loaded at the last step, freed by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_busy && w_uw.emit && !w_out_blocked) begin
            r_m_valid  <= 1'b1;
            r_m_forced <= r_forced;
            if (r_forced) begin
                r_m_data <= '0;
            end else begin
                r_m_data <= {r_w[2][SW-1:0], r_w[1][SW-1:0], r_w[0][SW-1:0]};
            end
        end else if (r_m_valid && m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire
